// ===== rtl/rcbs_pkg.sv =====
// shared types, constants and clamp helpers for the rgb cube scanner
`default_nettype none

package rcbs_pkg;

   localparam int unsigned LayerLeds  = 9;
   localparam int unsigned LayerCount = 3;
   localparam int unsigned CubeLeds   = LayerLeds * LayerCount;
   localparam int unsigned PhaseLast  = 44;

   localparam logic [5:0] PhasePlane1 = 6'd3;
   localparam logic [5:0] PhasePlane2 = 6'd9;
   localparam logic [5:0] PhasePlane3 = 6'd21;
   localparam logic [5:0] PhaseCount  = 6'd45;

   localparam logic OpWrite = 1'b0;
   localparam logic OpTick  = 1'b1;

   typedef logic [11:0] color_type;   // blue 11:8, green 7:4, red 3:0
   typedef color_type layer_row_type [LayerLeds];

   typedef struct packed {
      logic       en;
      logic [1:0] x;
      logic [1:0] y;
      logic [1:0] z;
      color_type  color;
   } wr_req_type;

   function automatic logic [1:0] clamp_coord(input logic signed [7:0] v);
      logic [1:0] r;
      if (v < 0) begin
         r = 2'd0;
      end else if (v > 8'sd2) begin
         r = 2'd2;
      end else begin
         r = v[1:0];
      end
      return r;
   endfunction

   function automatic logic [3:0] clamp_level(input logic signed [7:0] v);
      logic [3:0] r;
      if (v < 0) begin
         r = 4'd0;
      end else if (v > 8'sd15) begin
         r = 4'd15;
      end else begin
         r = v[3:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_cube_bam_scan_top.sv =====
// top level of the rgb cube frame store and bam layer scanner
//
// usage:
//   a request is taken at a rising edge with start high and busy low; busy
//   is always low, so a request may be issued every cycle.
//   req_op low writes one led colour: coordinates clamp to 0..2, levels to
//   0..15. no response follows a write.
//   req_op high is a scan tick: the 32-bit shift word for the current layer
//   appears on rsp_frame_word with rsp_valid high for exactly one cycle,
//   once the request has passed the input register and then the word register.
//   throughput is one request per cycle; a write is visible to any tick
//   issued after it, including the very next cycle.
//   the receiver cannot stall: each response must be taken in its cycle.
//   reset clears the colour store, the layer and phase counters and any
//   request in flight.
//   shifting the word out with a latch pulse is not part of this block.
`default_nettype none

module rgb_cube_bam_scan_top
   import rcbs_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_op,
   input  wire logic signed [7:0] req_pos_x,
   input  wire logic signed [7:0] req_pos_y,
   input  wire logic signed [7:0] req_pos_z,
   input  wire logic signed [7:0] req_red_level,
   input  wire logic signed [7:0] req_green_level,
   input  wire logic signed [7:0] req_blue_level,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_frame_word
);

   logic              valid_ff;
   logic              op_ff;
   logic signed [7:0] x_ff, y_ff, z_ff, r_ff, g_ff, b_ff;
   logic              accept;
   wr_req_type        wr_req;
   layer_row_type     row;
   logic [1:0]        layer;
   logic              tick;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op;
         x_ff  <= req_pos_x;
         y_ff  <= req_pos_y;
         z_ff  <= req_pos_z;
         r_ff  <= req_red_level;
         g_ff  <= req_green_level;
         b_ff  <= req_blue_level;
      end
   end

   always_comb begin
      wr_req.en    = valid_ff && (op_ff == OpWrite);
      wr_req.x     = clamp_coord(x_ff);
      wr_req.y     = clamp_coord(y_ff);
      wr_req.z     = clamp_coord(z_ff);
      wr_req.color = {clamp_level(b_ff), clamp_level(g_ff), clamp_level(r_ff)};
   end

   assign tick = valid_ff && (op_ff == OpTick);

   rcbs_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_req   (wr_req),
      .rd_layer (layer),
      .rd_row   (row)
   );

   rcbs_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .row        (row),
      .layer      (layer),
      .word_valid (rsp_valid),
      .word       (rsp_frame_word)
   );

`ifndef SYNTHESIS
   a_tick_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OpTick) |=> ##1 rsp_valid)
      else $error("tick request gave no response");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OpWrite) |=> ##1 !rsp_valid)
      else $error("write request gave a response");

   a_layer_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_frame_word[31:29]))
      else $error("layer select not one-hot");
`endif

endmodule

`default_nettype wire

// ===== rtl/rcbs_store.sv =====
// colour frame store: 27 leds of 12 bits, one write port, one layer read
`default_nettype none

module rcbs_store
   import rcbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire wr_req_type    wr_req,
   input  wire logic [1:0]    rd_layer,
   output layer_row_type      rd_row
);

   color_type store_ff [CubeLeds];
   logic [4:0] wr_idx;

   assign wr_idx = 5'({3'b000, wr_req.z} * 5'd9) + 5'({3'b000, wr_req.x})
                 + 5'({3'b000, wr_req.y} * 5'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CubeLeds; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_req.en) begin
         store_ff[wr_idx] <= wr_req.color;
      end
   end

   // layer three does not exist: its row reads as dark
   always_comb begin
      logic [4:0] base;
      base = 5'({3'b000, rd_layer} * 5'd9);
      for (int i = 0; i < LayerLeds; i++) begin
         if (rd_layer < 2'd3) begin
            rd_row[i] = store_ff[base + 5'(i)];
         end else begin
            rd_row[i] = '0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rcbs_scan.sv =====
// layer and bam phase counters, bit plane select and shift word register
`default_nettype none

module rcbs_scan
   import rcbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          tick,
   input  wire layer_row_type row,
   output logic [1:0]         layer,
   output logic               word_valid,
   output logic [31:0]        word
);

   logic [1:0]  layer_ff, layer_in;
   logic [5:0]  phase_ff, phase_in;
   logic        valid_ff;
   logic [31:0] word_ff, word_in;
   logic [1:0]  plane;
   logic        show;

   always_comb begin
      show = 1'b1;
      if (phase_ff < PhasePlane1) begin
         plane = 2'd0;
      end else if (phase_ff < PhasePlane2) begin
         plane = 2'd1;
      end else if (phase_ff < PhasePlane3) begin
         plane = 2'd2;
      end else if (phase_ff < PhaseCount) begin
         plane = 2'd3;
      end else begin
         plane = 2'd0;
         show  = 1'b0;
      end
   end

   always_comb begin
      word_in = '0;
      if (show) begin
         for (int i = 0; i < LayerLeds; i++) begin
            word_in[i]      = row[i][{2'b00, plane}];
            word_in[9 + i]  = row[i][4'd4 + {2'b00, plane}];
            word_in[18 + i] = row[i][4'd8 + {2'b00, plane}];
         end
      end
      unique case (layer_ff)
         2'd0:    word_in[31:29] = 3'b001;
         2'd1:    word_in[31:29] = 3'b010;
         2'd2:    word_in[31:29] = 3'b100;
         default: word_in[31:29] = 3'b000;
      endcase
      layer_in = (layer_ff >= 2'd2) ? 2'd0 : layer_ff + 2'd1;
      phase_in = (phase_ff >= 6'(PhaseLast)) ? 6'd0 : phase_ff + 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff <= '0;
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tick;
         if (tick) begin
            layer_ff <= layer_in;
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         word_ff <= word_in;
      end
   end

   assign layer      = layer_ff;
   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

`default_nettype wire
